// File: rtl/ctwc_pkg.sv
// Package for the C word token classifier: types, keyword tables and character codes.
package ctwc_pkg;

  localparam int KwCount = 32;
  localparam int KwMaxLen = 8;
  localparam int LenW = 4;
  localparam logic [LenW-1:0] LenMax = '1;

  typedef enum logic [2:0] {
    CLS_ARITH   = 3'd0,
    CLS_REL     = 3'd1,
    CLS_KEYWORD = 3'd2,
    CLS_IDENT   = 3'd3,
    CLS_FLOAT   = 3'd4,
    CLS_INTEGER = 3'd5,
    CLS_UNKNOWN = 3'd6
  } token_class_e;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  // keyword text, right-justified: first character in the highest used byte
  localparam logic [8*KwMaxLen-1:0] KwText [KwCount] = '{
    64'("auto"), 64'("break"), 64'("case"), 64'("char"),
    64'("const"), 64'("continue"), 64'("default"), 64'("do"),
    64'("double"), 64'("else"), 64'("enum"), 64'("extern"),
    64'("float"), 64'("for"), 64'("goto"), 64'("if"),
    64'("int"), 64'("long"), 64'("register"), 64'("return"),
    64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"),
    64'("struct"), 64'("switch"), 64'("typedef"), 64'("union"),
    64'("unsigned"), 64'("void"), 64'("volatile"), 64'("while")
  };

  localparam logic [LenW-1:0] KwLen [KwCount] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
  };

  typedef struct packed {
    logic [KwCount-1:0] kw_cand;
    logic [LenW-1:0]    len;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic [1:0]         dot_cnt;
    logic               nondigit;
    logic               digit_after_dot;
  } word_t;

  // empty word: every keyword still possible
  localparam word_t WordClear = '{kw_cand: '1, default: '0};

  function automatic logic [7:0] kw_char(input int k, input int p);
    int sh;
    sh = 8 * (int'(KwLen[k]) - 1 - p);
    if (p < int'(KwLen[k])) begin
      return KwText[k][sh +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ));
  endfunction

endpackage

// File: rtl/c_word_token_classifier_top.sv
// Top level of the C word token classifier.
// Flow: a character item is taken into the input register and processed from there by the
// word state update; the class of a word is registered as its last character leaves that register.
// Throughput: one character per cycle, unless a word's last character waits on a stalled output.
// Reset: asynchronous, active low; clears both pipeline valids and the word state.
module c_word_token_classifier_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       word_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_class_o
);
  import ctwc_pkg::*;

  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   s1_char_q;
  logic         s1_end_q;
  logic         out_valid_q, out_valid_d;
  token_class_e class_q, cls;
  logic         out_free, s1_adv, in_acc;
  word_t        word;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_end_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  ctwc_word_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .char_code_i (s1_char_q),
    .word_end_i  (s1_end_q),
    .word_o      (word)
  );

  ctwc_classify u_classify (
    .word_i  (word),
    .class_o (cls)
  );

  always_comb begin
    s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
    out_valid_d = (s1_adv && s1_end_q) || (out_valid_q && !out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= char_code_i;
      s1_end_q  <= word_end_i;
    end
    if (s1_adv && s1_end_q) begin
      class_q <= cls;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_class_o = class_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_end_q) |=> out_valid_o)
    else $error("last character did not produce a result");

  a_taken_result_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(s1_adv && s1_end_q)) |=> !out_valid_o)
    else $error("result repeated");

  a_mid_word_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !(s1_adv && s1_end_q)) |=>
      (out_valid_o && $stable(token_class_o)))
    else $error("held result disturbed by a mid-word character");
`endif

endmodule

// File: rtl/ctwc_word_state.sv
// Per-word state registers and their update for one character.
module ctwc_word_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       char_code_i,
  input  logic             word_end_i,
  output ctwc_pkg::word_t  word_o
);
  import ctwc_pkg::*;

  word_t word_q, word_d, upd;
  logic  [KwCount-1:0] keep;

  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      keep[k] = 1'b0;
      for (int p = 0; p < KwMaxLen; p++) begin
        if ((p < int'(KwLen[k])) && (word_q.len == LenW'(p)) &&
            (char_code_i == kw_char(k, p))) begin
          keep[k] = 1'b1;
        end
      end
    end

    upd             = word_q;
    upd.kw_cand     = word_q.kw_cand & keep;
    if (word_q.len == '0) begin
      upd.first_char = char_code_i;
    end
    if (word_q.len == LenW'(1)) begin
      upd.second_char = char_code_i;
    end
    if (char_code_i == ChDot) begin
      if (word_q.dot_cnt != 2'd2) begin
        upd.dot_cnt = word_q.dot_cnt + 2'd1;
      end
    end else if (is_digit(char_code_i)) begin
      if (word_q.dot_cnt != 2'd0) begin
        upd.digit_after_dot = 1'b1;
      end
    end else begin
      upd.nondigit = 1'b1;
    end
    if (word_q.len != LenMax) begin
      upd.len = word_q.len + LenW'(1);
    end

    word_d = word_q;
    if (adv_i) begin
      if (word_end_i) begin
        word_d = WordClear;
      end else begin
        word_d = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= WordClear;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = upd;

endmodule

// File: rtl/ctwc_classify.sv
// Priority classification of a finished word.
module ctwc_classify (
  input  ctwc_pkg::word_t        word_i,
  output ctwc_pkg::token_class_e class_o
);
  import ctwc_pkg::*;

  logic [KwCount-1:0] len_hit;
  logic arith1, rel1, rel2, kw, flt, intg;

  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      len_hit[k] = (KwLen[k] == word_i.len);
    end
    kw = |(word_i.kw_cand & len_hit);

    arith1 = (word_i.len == LenW'(1)) &&
             ((word_i.first_char == ChPlus) || (word_i.first_char == ChMinus) ||
              (word_i.first_char == ChStar) || (word_i.first_char == ChSlash) ||
              (word_i.first_char == ChPct)  || (word_i.first_char == ChCaret) ||
              (word_i.first_char == ChEq));
    rel1 = (word_i.len == LenW'(1)) &&
           ((word_i.first_char == ChLt) || (word_i.first_char == ChGt));
    rel2 = (word_i.len == LenW'(2)) && (word_i.second_char == ChEq) &&
           ((word_i.first_char == ChBang) || (word_i.first_char == ChEq) ||
            (word_i.first_char == ChLt)   || (word_i.first_char == ChGt));
    flt  = (word_i.dot_cnt == 2'd1) && !word_i.nondigit && word_i.digit_after_dot &&
           !((word_i.first_char == ChZero) && (word_i.second_char != ChDot));
    intg = (word_i.dot_cnt == 2'd0) && !word_i.nondigit;

    priority if (arith1) begin
      class_o = CLS_ARITH;
    end else if (rel1 || rel2) begin
      class_o = CLS_REL;
    end else if (kw) begin
      class_o = CLS_KEYWORD;
    end else if (is_letter(word_i.first_char)) begin
      class_o = CLS_IDENT;
    end else if (flt) begin
      class_o = CLS_FLOAT;
    end else if (intg) begin
      class_o = CLS_INTEGER;
    end else begin
      class_o = CLS_UNKNOWN;
    end
  end

endmodule

// File: verif/ctwc_checker.sv
// Checker for the C word token classifier: watches both channels, predicts and compares classes.
`timescale 1ns / 1ps

module ctwc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_code_i,
  input  logic       word_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] token_class_i,
  output int         fail_count_o,
  output int         pending_o
);
  import ctwc_pkg::*;

  string kw_words [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof",
    "static", "struct", "switch", "typedef", "union", "unsigned", "void",
    "volatile", "while"
  };

  logic [31:0]  kw_live;
  logic [3:0]   wlen;
  logic [7:0]   c0;
  logic [7:0]   c1;
  logic [1:0]   dots;
  logic         odd_seen;
  logic         frac_digit;
  token_class_e pending_classes [$];
  token_class_e want;
  int           mismatches = 0;
  int           pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic numeral(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic alpha(input logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ);
  endfunction

  function automatic void clear_word();
    kw_live    = '1;
    wlen       = '0;
    c0         = '0;
    c1         = '0;
    dots       = '0;
    odd_seen   = 1'b0;
    frac_digit = 1'b0;
  endfunction

  function automatic token_class_e classify_word();
    logic kw_hit;
    kw_hit = 1'b0;
    if (wlen == 4'd1) begin
      case (c0)
        ChPlus, ChMinus, ChStar, ChSlash, ChPct, ChCaret, ChEq: return CLS_ARITH;
        ChLt, ChGt: return CLS_REL;
        default: ;
      endcase
    end
    if (wlen == 4'd2 && c1 == ChEq && (c0 == ChBang || c0 == ChEq || c0 == ChLt || c0 == ChGt))
      return CLS_REL;
    for (int k = 0; k < 32; k++) begin
      if (kw_live[k] && kw_words[k].len() == wlen) kw_hit = 1'b1;
    end
    if (kw_hit) return CLS_KEYWORD;
    if (alpha(c0)) return CLS_IDENT;
    if (dots == 2'd1 && !odd_seen && frac_digit && !(c0 == ChZero && c1 != ChDot))
      return CLS_FLOAT;
    if (dots == 2'd0 && !odd_seen) return CLS_INTEGER;
    return CLS_UNKNOWN;
  endfunction

  function automatic void absorb_char(input logic [7:0] c, input logic last);
    logic [7:0] kc;
    for (int k = 0; k < 32; k++) begin
      kc = kw_words[k][wlen];
      if (wlen >= kw_words[k].len() || kc != c) kw_live[k] = 1'b0;
    end
    if (wlen == 4'd0) c0 = c;
    else if (wlen == 4'd1) c1 = c;
    if (c == ChDot) begin
      if (dots < 2'd2) dots++;
    end else if (numeral(c)) begin
      if (dots != 2'd0) frac_digit = 1'b1;
    end else begin
      odd_seen = 1'b1;
    end
    if (wlen < 4'd15) wlen++;
    if (last) begin
      pending_classes.push_back(classify_word());
      clear_word();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_word();
      pending_classes.delete();
      pending <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_classes.size() == 0) begin
          report_mismatch($sformatf("class %0d with no word pending", token_class_i));
        end else begin
          want = pending_classes.pop_front();
          if (token_class_i !== want)
            report_mismatch($sformatf("class %0d, expected %0d (%s)",
                                      token_class_i, want, want.name()));
        end
      end
      if (in_valid_i && !in_stall_i) absorb_char(char_code_i, word_end_i);
      pending <= pending_classes.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the C word token classifier: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ctwc_pkg::*;

  localparam int TargetChars = 550;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i = 8'h00;
  logic       word_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] token_class_o;
  int         fail_count;
  int         pending;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         chars_sent = 0;
  logic [7:0] word_buf [$];

  string kw_words [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof",
    "static", "struct", "switch", "typedef", "union", "unsigned", "void",
    "volatile", "while"
  };
  string op_words [13] = '{
    "+", "-", "*", "/", "%", "^", "=", "<", ">", "!=", "==", "<=", ">="
  };
  string punct = "+-*/%^=<>!._";

  c_word_token_classifier_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .word_end_i   (word_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_class_o(token_class_o)
  );

  ctwc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .char_code_i  (char_code_i),
    .word_end_i   (word_end_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_class_i(token_class_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return ChLowA + 8'($urandom_range(25));
    return ChUpA + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return ChZero + 8'($urandom_range(9));
  endfunction

  function automatic int pick_len();
    if ($urandom_range(9) == 0) return $urandom_range(20, 10);
    return $urandom_range(6);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) word_buf.push_back(rand_digit());
  endfunction

  task automatic set_idling(input int ph);
    case (ph)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 54; end
      default: begin send_idle_pct = 9; recv_stall_pct <= 9; end
    endcase
  endtask

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    word_end_i  <= last;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++) send_char(word_buf[i], i == word_buf.size() - 1);
    chars_sent += word_buf.size();
  endtask

  task automatic send_text(input string s);
    word_buf.delete();
    add_text(s);
    send_word();
  endtask

  task automatic make_random_word();
    int n;
    word_buf.delete();
    case ($urandom_range(9))
      0: add_text(op_words[$urandom_range(12)]);
      1, 2: begin
        add_text(kw_words[$urandom_range(31)]);
        case ($urandom_range(3))
          0: word_buf.push_back(rand_letter());
          1: void'(word_buf.pop_back());
          2: word_buf[$urandom_range(word_buf.size() - 1)] = rand_letter();
          default: ;
        endcase
      end
      3: begin
        word_buf.push_back(rand_letter());
        n = pick_len();
        repeat (n) begin
          case ($urandom_range(3))
            0: word_buf.push_back(rand_digit());
            1: word_buf.push_back(punct[$urandom_range(punct.len() - 1)]);
            default: word_buf.push_back(rand_letter());
          endcase
        end
      end
      4: add_digits(pick_len() + 1);
      5, 6: begin
        case ($urandom_range(3))
          0: word_buf.push_back(ChZero);
          1: ;
          default: add_digits($urandom_range(5, 1));
        endcase
        word_buf.push_back(ChDot);
        add_digits($urandom_range(9) == 0 ? 0 : pick_len() + 1);
      end
      7: begin
        add_digits($urandom_range(4));
        n = $urandom_range(2);
        case (n)
          0: word_buf.push_back(ChDot);
          1: word_buf.push_back(rand_letter());
          default: word_buf.push_back(punct[$urandom_range(punct.len() - 1)]);
        endcase
        add_digits($urandom_range(4));
        if ($urandom_range(1)) word_buf.push_back(ChDot);
        add_digits($urandom_range(3));
      end
      8: begin
        n = $urandom_range(6, 1);
        repeat (n) word_buf.push_back(8'($urandom_range(255)));
      end
      default: begin
        word_buf.push_back(punct[$urandom_range(punct.len() - 1)]);
        if ($urandom_range(3) != 0) word_buf.push_back(punct[$urandom_range(punct.len() - 1)]);
      end
    endcase
  endtask

  initial begin
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("+");
    send_text("<=");
    send_text("!=");
    send_text("while");
    send_text("0.5");
    send_text("05.1");
    send_text("1.");
    send_text("12");
    word_buf.delete();
    word_buf.push_back(8'h00);
    send_word();
    word_buf.delete();
    word_buf.push_back(8'hFF);
    send_word();

    while (chars_sent < TargetChars) begin
      set_idling(chars_sent * 4 / TargetChars);
      make_random_word();
      send_word();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_top failed");
    $finish;
  end

endmodule
